@@ sv/bgwb_pkg.sv @@
`timescale 1ns / 1ps

package bgwb_pkg;

  // frame geometry
  localparam int MAX_WIDTH      = 256;
  localparam int MAX_HEIGHT     = 256;
  localparam int COL_W          = $clog2(MAX_WIDTH);
  localparam int ROW_W          = $clog2(MAX_HEIGHT);
  localparam int ADDR_W         = COL_W + ROW_W;

  // field and register widths
  localparam int PIX_W          = 16;
  localparam int DIM_W          = 9;
  localparam int CFG_W          = 9;
  localparam int CFG_IDX_W      = 2;
  localparam int SUM_W          = 32;
  localparam int QUAD_W         = 2 * (DIM_W - 1);

  // gain format, unsigned 8.16
  localparam int GAIN_FRAC_BITS = 16;
  localparam int GAIN_W         = 24;
  localparam int PROD_W         = PIX_W + GAIN_W;
  localparam int SCALED_W       = PROD_W - GAIN_FRAC_BITS;

  // shared divider: sum / quad count, or (green sum of means) << frac / twice a mean
  localparam int DEN_W          = SUM_W + 1;
  localparam int NUM_W          = DEN_W + GAIN_FRAC_BITS;
  localparam int DIV_CNT_W      = $clog2(NUM_W + 1);

  localparam logic [DIM_W-1:0]  RESET_FRAME_DIM = DIM_W'(256);
  localparam logic [GAIN_W-1:0] GAIN_UNITY      = GAIN_W'(1) << GAIN_FRAC_BITS;
  localparam logic [GAIN_W-1:0] GAIN_MAX        = '1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_BYTE_MODE    = CFG_IDX_W'(2);

  typedef enum logic {
    FUNC_LOAD  = 1'b0,
    FUNC_FETCH = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    SITE_RED    = 2'd0,
    SITE_GREEN0 = 2'd1,
    SITE_GREEN1 = 2'd2,
    SITE_BLUE   = 2'd3
  } site_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH_RD,
    ST_FETCH_OUT,
    ST_DIV_START,
    ST_DIV_WAIT
  } state_t;

  typedef enum logic [2:0] {
    STEP_RED_MEAN,
    STEP_G0_MEAN,
    STEP_G1_MEAN,
    STEP_BLUE_MEAN,
    STEP_RED_GAIN,
    STEP_BLUE_GAIN
  } step_t;

  typedef struct packed {
    func_t              func;
    logic [PIX_W-1:0]   pixel_in;
  } bgwb_in_t;

  typedef struct packed {
    logic [PIX_W-1:0]   pixel_out;
    logic               frame_last;
  } bgwb_out_t;

  typedef struct packed {
    logic               start;
    logic [NUM_W-1:0]   dividend;
    logic [DEN_W-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [NUM_W-1:0]   quotient;
  } div_rsp_t;

  typedef struct packed {
    logic               en;
    logic [ADDR_W-1:0]  addr;
    logic [PIX_W-1:0]   data;
  } store_wr_t;

  // clamp a dimension into [2, maxv] and force it even
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] c;
    c = v;
    if (v < DIM_W'(2)) c = DIM_W'(2);
    if (v > maxv) c = maxv;
    return {c[DIM_W-1:1], 1'b0};
  endfunction

  // bayer site from row and column parity
  function automatic site_t site_of(input logic row_odd, input logic col_odd);
    site_t s;
    if (row_odd) s = col_odd ? SITE_GREEN0 : SITE_RED;
    else         s = col_odd ? SITE_GREEN1 : SITE_BLUE;
    return s;
  endfunction

endpackage

@@ sv/bgwb_div.sv @@
`timescale 1ns / 1ps

module bgwb_div import bgwb_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [NUM_W-1:0]     num_r;
  logic [DEN_W-1:0]     den_r;
  logic [DEN_W-1:0]     rem_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;

  logic [DEN_W:0]       rem_sh;
  logic [DEN_W:0]       rem_diff;
  logic                 q_bit;

  // one restoring step: shift in next dividend bit, subtract if it fits
  always_comb begin
    rem_sh   = {rem_r, num_r[NUM_W-1]};
    rem_diff = rem_sh - {1'b0, den_r};
    q_bit    = (rem_sh >= {1'b0, den_r});
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath, quotient bits shift into the dividend register
  always_ff @(posedge clk) begin
    if (req.start) begin
      num_r <= req.dividend;
      den_r <= req.divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[NUM_W-2:0], q_bit};
      rem_r <= q_bit ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = num_r;

endmodule

@@ sv/bgwb_store.sv @@
`timescale 1ns / 1ps

module bgwb_store import bgwb_pkg::*; (
  input  logic              clk,
  input  store_wr_t         wr,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [PIX_W-1:0]  rd_data
);

  logic [PIX_W-1:0] store_mem [2**ADDR_W];
  logic [PIX_W-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      store_mem[wr.addr] <= wr.data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= store_mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ sv/bgwb_scale.sv @@
`timescale 1ns / 1ps

module bgwb_scale import bgwb_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [PIX_W-1:0]  pixel,
  input  logic [GAIN_W-1:0] gain,
  output logic [PIX_W-1:0]  scaled
);

  logic [PROD_W-1:0]   prod;
  logic [SCALED_W-1:0] scaled_r;

  // pixel times gain, fraction dropped
  assign prod = PROD_W'(pixel) * PROD_W'(gain);

  always_ff @(posedge clk) begin
    if (en) begin
      scaled_r <= prod[PROD_W-1:GAIN_FRAC_BITS];
    end
  end

  // saturate to full scale
  assign scaled = (|scaled_r[SCALED_W-1:PIX_W]) ? '1 : scaled_r[PIX_W-1:0];

endmodule

@@ sv/bayer_gray_world_balance_core.sv @@
`timescale 1ns / 1ps
// channel | direction | handshake            | word
// in_     | input     | in_valid / in_stall  | bgwb_in_t  (func, pixel_in)
// out_    | output    | out_valid / out_stall| bgwb_out_t (pixel_out, frame_last)
// cfg_    | input     | cfg_we               | cfg_index, cfg_data
//
// a load word is taken only while idle; the last load of a frame then runs the
// shared 49-step divider up to six times, a zero mean skipping its gain, and stalls input
// a fetch word runs in order: store read, gain multiply, output register load
// a fetch waits in its output load state while the output register holds a stalled word
// reset is synchronous; frame store contents are undefined and never cleared

module bayer_gray_world_balance_core import bgwb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  bgwb_in_t             in_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output bgwb_out_t            out_word,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  state_t             state_r, state_nxt;
  step_t              step_r, step_nxt;

  logic [DIM_W-1:0]   width_r;
  logic [DIM_W-1:0]   height_r;
  logic               byte_mode_r;

  logic [ROW_W-1:0]   row_r;
  logic [COL_W-1:0]   col_r;
  logic               frame_ready_r;
  logic               kill_r;

  logic [SUM_W-1:0]   red_sum_r, g0_sum_r, g1_sum_r, blue_sum_r;
  logic [SUM_W-1:0]   red_mean_r, g0_mean_r, g1_mean_r, blue_mean_r;
  logic [GAIN_W-1:0]  red_gain_r, blue_gain_r;

  site_t              fsite_r;
  logic               flast_r;

  logic               out_valid_r;
  bgwb_out_t          out_word_r;

  logic [DIM_W-1:0]   w_eff, h_eff;
  logic [QUAD_W-1:0]  quad_n;
  logic [DEN_W-1:0]   green_two;
  logic               last_col, last_row;
  site_t              site_cur;
  logic               accept, is_load, is_fetch, cfg_hit, dividing;
  logic [SUM_W-1:0]   add_val;
  logic [PIX_W-1:0]   store_val;
  logic               out_free, load_out;
  logic               step_wr, step_skip, step_adv, finish;
  logic [GAIN_W-1:0]  gain_q, gain_sel;
  logic [PIX_W-1:0]   scaled;
  logic [PIX_W-1:0]   rd_data;

  div_req_t           div_req;
  div_rsp_t           div_rsp;
  store_wr_t          store_wr;

  // effective geometry
  assign w_eff     = clamp_dim(width_r, DIM_W'(MAX_WIDTH));
  assign h_eff     = clamp_dim(height_r, DIM_W'(MAX_HEIGHT));
  assign quad_n    = QUAD_W'(w_eff[DIM_W-1:1]) * QUAD_W'(h_eff[DIM_W-1:1]);
  assign last_col  = (DIM_W'(col_r) == w_eff - DIM_W'(1));
  assign last_row  = (DIM_W'(row_r) == h_eff - DIM_W'(1));
  assign site_cur  = site_of(row_r[0], col_r[0]);
  assign green_two = {1'b0, g0_mean_r} + {1'b0, g1_mean_r};

  // handshake decode
  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign is_load   = accept && (in_word.func == FUNC_LOAD) && !frame_ready_r;
  assign is_fetch  = accept && (in_word.func == FUNC_FETCH) && frame_ready_r;
  assign cfg_hit   = cfg_we && ((cfg_index == CFG_FRAME_WIDTH) ||
                                (cfg_index == CFG_FRAME_HEIGHT) ||
                                (cfg_index == CFG_BYTE_MODE));
  assign dividing  = (state_r == ST_DIV_START) || (state_r == ST_DIV_WAIT);
  assign out_free  = !out_valid_r || !out_stall;

  // pixel format
  assign add_val   = byte_mode_r ? SUM_W'(in_word.pixel_in[7:0]) : SUM_W'(in_word.pixel_in);
  assign store_val = byte_mode_r ? {in_word.pixel_in[7:0], 8'h00} : in_word.pixel_in;

  // saturated gain from divider quotient
  assign gain_q = (|div_rsp.quotient[NUM_W-1:GAIN_W]) ? GAIN_MAX
                                                       : div_rsp.quotient[GAIN_W-1:0];

  // sequencer state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= STEP_RED_MEAN;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  // sequencer next state and divider requests
  always_comb begin
    state_nxt        = state_r;
    step_nxt         = step_r;
    div_req          = '0;
    step_wr          = 1'b0;
    step_skip        = 1'b0;
    load_out         = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (is_fetch) begin
          state_nxt = ST_FETCH_RD;
        end else if (is_load && last_col && last_row) begin
          state_nxt = ST_DIV_START;
          step_nxt  = STEP_RED_MEAN;
        end
      end
      ST_FETCH_RD: begin
        state_nxt = ST_FETCH_OUT;
      end
      ST_FETCH_OUT: begin
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_DIV_START: begin
        case (step_r)
          STEP_RED_MEAN: begin
            div_req.start    = 1'b1;
            div_req.dividend = NUM_W'(red_sum_r);
            div_req.divisor  = DEN_W'(quad_n);
          end
          STEP_G0_MEAN: begin
            div_req.start    = 1'b1;
            div_req.dividend = NUM_W'(g0_sum_r);
            div_req.divisor  = DEN_W'(quad_n);
          end
          STEP_G1_MEAN: begin
            div_req.start    = 1'b1;
            div_req.dividend = NUM_W'(g1_sum_r);
            div_req.divisor  = DEN_W'(quad_n);
          end
          STEP_BLUE_MEAN: begin
            div_req.start    = 1'b1;
            div_req.dividend = NUM_W'(blue_sum_r);
            div_req.divisor  = DEN_W'(quad_n);
          end
          STEP_RED_GAIN: begin
            if (red_mean_r == '0) begin
              step_skip = 1'b1;
            end else begin
              div_req.start    = 1'b1;
              div_req.dividend = {green_two, {GAIN_FRAC_BITS{1'b0}}};
              div_req.divisor  = {red_mean_r, 1'b0};
            end
          end
          default: begin
            if (blue_mean_r == '0) begin
              step_skip = 1'b1;
            end else begin
              div_req.start    = 1'b1;
              div_req.dividend = {green_two, {GAIN_FRAC_BITS{1'b0}}};
              div_req.divisor  = {blue_mean_r, 1'b0};
            end
          end
        endcase
        if (div_req.start) begin
          state_nxt = ST_DIV_WAIT;
        end
      end
      ST_DIV_WAIT: begin
        step_wr = div_rsp.done;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // advance to the next division or finish the frame
    if (step_wr || step_skip) begin
      if (step_r == STEP_BLUE_GAIN) begin
        state_nxt = ST_IDLE;
      end else begin
        state_nxt = ST_DIV_START;
        case (step_r)
          STEP_RED_MEAN:  step_nxt = STEP_G0_MEAN;
          STEP_G0_MEAN:   step_nxt = STEP_G1_MEAN;
          STEP_G1_MEAN:   step_nxt = STEP_BLUE_MEAN;
          STEP_BLUE_MEAN: step_nxt = STEP_RED_GAIN;
          default:        step_nxt = STEP_BLUE_GAIN;
        endcase
      end
    end
  end

  assign step_adv = step_wr || step_skip;
  assign finish   = step_adv && (step_r == STEP_BLUE_GAIN);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= RESET_FRAME_DIM;
      height_r    <= RESET_FRAME_DIM;
      byte_mode_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:  width_r     <= cfg_data[DIM_W-1:0];
        CFG_FRAME_HEIGHT: height_r    <= cfg_data[DIM_W-1:0];
        CFG_BYTE_MODE:    byte_mode_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // raster position, shared by load and fetch
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_hit) begin
      row_r <= '0;
      col_r <= '0;
    end else if (is_load || is_fetch) begin
      if (last_col) begin
        col_r <= '0;
        row_r <= last_row ? '0 : row_r + ROW_W'(1);
      end else begin
        col_r <= col_r + COL_W'(1);
      end
    end
  end

  // frame ready and abandon during gain computation
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_ready_r <= 1'b0;
      kill_r        <= 1'b0;
    end else begin
      if (cfg_hit) begin
        frame_ready_r <= 1'b0;
      end else if (finish) begin
        frame_ready_r <= !kill_r;
      end else if (is_fetch && last_col && last_row) begin
        frame_ready_r <= 1'b0;
      end
      if (finish) begin
        kill_r <= 1'b0;
      end else if (cfg_hit && dividing) begin
        kill_r <= 1'b1;
      end
    end
  end

  // site sums
  always_ff @(posedge clk) begin
    if (!rst_n || (cfg_hit && !dividing) || finish) begin
      red_sum_r  <= '0;
      g0_sum_r   <= '0;
      g1_sum_r   <= '0;
      blue_sum_r <= '0;
    end else if (is_load) begin
      case (site_cur)
        SITE_RED:    red_sum_r  <= red_sum_r + add_val;
        SITE_GREEN0: g0_sum_r   <= g0_sum_r + add_val;
        SITE_GREEN1: g1_sum_r   <= g1_sum_r + add_val;
        default:     blue_sum_r <= blue_sum_r + add_val;
      endcase
    end
  end

  // site means from the divider
  always_ff @(posedge clk) begin
    if (step_wr) begin
      case (step_r)
        STEP_RED_MEAN:  red_mean_r  <= div_rsp.quotient[SUM_W-1:0];
        STEP_G0_MEAN:   g0_mean_r   <= div_rsp.quotient[SUM_W-1:0];
        STEP_G1_MEAN:   g1_mean_r   <= div_rsp.quotient[SUM_W-1:0];
        STEP_BLUE_MEAN: blue_mean_r <= div_rsp.quotient[SUM_W-1:0];
        default: ;
      endcase
    end
  end

  // gains, saturated on a zero mean
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_gain_r  <= GAIN_UNITY;
      blue_gain_r <= GAIN_UNITY;
    end else if (step_adv) begin
      if (step_r == STEP_RED_GAIN) begin
        red_gain_r <= step_skip ? GAIN_MAX : gain_q;
      end else if (step_r == STEP_BLUE_GAIN) begin
        blue_gain_r <= step_skip ? GAIN_MAX : gain_q;
      end
    end
  end

  // fetch pipeline tags
  always_ff @(posedge clk) begin
    if (is_fetch) begin
      fsite_r <= site_cur;
      flast_r <= last_col && last_row;
    end
  end

  // gain for the fetched site, green passes at unity
  always_comb begin
    case (fsite_r)
      SITE_RED:  gain_sel = red_gain_r;
      SITE_BLUE: gain_sel = blue_gain_r;
      default:   gain_sel = GAIN_UNITY;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_word_r.pixel_out  <= scaled;
      out_word_r.frame_last <= flast_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // frame store write
  assign store_wr.en   = is_load;
  assign store_wr.addr = {row_r, col_r};
  assign store_wr.data = store_val;

  bgwb_store u_store (
    .clk     (clk),
    .wr      (store_wr),
    .rd_en   (is_fetch),
    .rd_addr ({row_r, col_r}),
    .rd_data (rd_data)
  );

  bgwb_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  bgwb_scale u_scale (
    .clk    (clk),
    .en     (state_r == ST_FETCH_RD),
    .pixel  (rd_data),
    .gain   (gain_sel),
    .scaled (scaled)
  );

endmodule

@@ sv/bgwb_checker.sv @@
`timescale 1ns / 1ps

module bgwb_checker import bgwb_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input bgwb_in_t  in_word,
  input logic      out_valid,
  input logic      out_stall,
  input bgwb_out_t out_word
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("stalled output word changed");

  // reset leaves the block empty and ready
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("block not empty after reset");

  // a new result appears only after a fetch word is taken
  a_fetch_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall && (in_word.func == FUNC_FETCH), 3))
    else $error("result word without a matching fetch");

endmodule

bind bayer_gray_world_balance_core bgwb_checker u_bgwb_checker (.*);
